### design/csl_pkg.sv
package csl_pkg;

  localparam int unsigned TEXT_LEN_MAX_DEF = 1048575;

  localparam int OUT_W = 20;
  localparam int VAL_W = 63;
  localparam int KIND_W = 5;
  localparam int ERR_W = 2;
  localparam int MODE_W = 3;

  localparam logic [VAL_W-1:0] NUM_MAX = {VAL_W{1'b1}};

  localparam logic [MODE_W-1:0] M_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] M_PUNCT = 3'd1;
  localparam logic [MODE_W-1:0] M_WORD  = 3'd2;
  localparam logic [MODE_W-1:0] M_NUM   = 3'd3;
  localparam logic [MODE_W-1:0] M_STR   = 3'd4;
  localparam logic [MODE_W-1:0] M_LCOM  = 3'd5;
  localparam logic [MODE_W-1:0] M_BCOM  = 3'd6;
  localparam logic [MODE_W-1:0] M_ERR   = 3'd7;

  localparam logic [KIND_W-1:0] K_PUNCT    = 5'd0;
  localparam logic [KIND_W-1:0] K_RETURN   = 5'd1;
  localparam logic [KIND_W-1:0] K_EXTERN   = 5'd2;
  localparam logic [KIND_W-1:0] K_ENUM     = 5'd3;
  localparam logic [KIND_W-1:0] K_STRUCT   = 5'd4;
  localparam logic [KIND_W-1:0] K_TYPEDEF  = 5'd5;
  localparam logic [KIND_W-1:0] K_IF       = 5'd6;
  localparam logic [KIND_W-1:0] K_WHILE    = 5'd7;
  localparam logic [KIND_W-1:0] K_FOR      = 5'd8;
  localparam logic [KIND_W-1:0] K_TYPE     = 5'd9;
  localparam logic [KIND_W-1:0] K_BREAK    = 5'd10;
  localparam logic [KIND_W-1:0] K_CONTINUE = 5'd11;
  localparam logic [KIND_W-1:0] K_NUM      = 5'd12;
  localparam logic [KIND_W-1:0] K_STR      = 5'd13;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd14;
  localparam logic [KIND_W-1:0] K_EOF      = 5'd15;
  localparam logic [KIND_W-1:0] K_ERROR    = 5'd16;

  localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] E_BCOM    = 2'd1;
  localparam logic [ERR_W-1:0] E_STR     = 2'd2;
  localparam logic [ERR_W-1:0] E_INVALID = 2'd3;

  typedef struct packed {
    logic              last;
    logic [ERR_W-1:0]  error_code;
    logic [VAL_W-1:0]  value;
    logic [OUT_W-1:0]  length;
    logic [OUT_W-1:0]  start_res;
    logic [KIND_W-1:0] kind;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_pair_start(input logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" ||
           c == "+" || c == "-" || c == "*" || c == "/" || c == "%";
  endfunction

  function automatic logic is_single_only(input logic [7:0] c);
    return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]" ||
           c == ";" || c == ",";
  endfunction

  function automatic logic is_pair(input logic [7:0] p, input logic [7:0] c);
    return (p == "=" && c == "=") || (p == "!" && c == "=") || (p == "<" && c == "=") ||
           (p == ">" && c == "=") || (p == "&" && c == "&") || (p == "|" && c == "|") ||
           (p == "+" && c == "+") || (p == "-" && c == "-") || (p == "+" && c == "=") ||
           (p == "-" && c == "=") || (p == "*" && c == "=") || (p == "/" && c == "=") ||
           (p == "%" && c == "=") || (p == "-" && c == ">");
  endfunction

  // whole-word keyword lookup on the packed prefix, first byte highest
  function automatic logic [KIND_W-1:0] kw_kind(input logic [63:0] w, input logic [3:0] len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    unique case (len)
      4'd2: begin
        if (w == 64'h6966) k = K_IF;
      end
      4'd3: begin
        if (w == 64'h666f72) k = K_FOR;
        else if (w == 64'h696e74) k = K_TYPE;
      end
      4'd4: begin
        if (w == 64'h656c7365) k = K_PUNCT;
        else if (w == 64'h656e756d) k = K_ENUM;
        else if (w == 64'h63686172) k = K_TYPE;
        else if (w == 64'h766f6964) k = K_TYPE;
      end
      4'd5: begin
        if (w == 64'h7768696c65) k = K_WHILE;
        else if (w == 64'h627265616b) k = K_BREAK;
      end
      4'd6: begin
        if (w == 64'h73697a656f66) k = K_PUNCT;
        else if (w == 64'h72657475726e) k = K_RETURN;
        else if (w == 64'h657874657266) k = K_IDENT;
        else if (w == 64'h65787465726e) k = K_EXTERN;
        else if (w == 64'h737472756374) k = K_STRUCT;
      end
      4'd7: begin
        if (w == 64'h74797065646566) k = K_TYPEDEF;
      end
      4'd8: begin
        if (w == 64'h636f6e74696e7565) k = K_CONTINUE;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### design/c_subset_lexer.sv
// Streaming lexer for a small C subset. One source byte enters per beat on the in_ side
// (in_tlast or a zero byte ends the text, flushes any open token and yields an eof token);
// tokens leave on the out_ side with their kind in out_tuser. While the queue has room, a
// byte is taken every cycle: it passes an input register and a combinational step of
// classification and state update, and its tokens land in a four-entry result queue.
// A byte yields two tokens only when it closes a pending token and is itself a one-byte
// token, an invalid byte or the end of text; the byte after it starts from idle or error
// mode and cannot yield two, so with out_tready held high the queue drains one token per
// cycle and bytes keep flowing at one per cycle. The input stalls only while the queue holds
// three or more tokens, that is while the output is held off.
// After an error token, bytes are dropped until the end of the text. Offsets and lengths
// saturate at TEXT_LEN_MAX and are reported in their low 20 bits.
module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int unsigned TEXT_LEN_MAX = TEXT_LEN_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // ch
  input  logic          in_tlast,   // end_of_text
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // start_res, length, value, error_code, zero pad
  output logic [4:0]    out_tuser,  // kind
  output logic          out_tlast   // last
);

  localparam int POS_W = $clog2(64'(TEXT_LEN_MAX) + 64'd1);
  localparam int CNT_W = (POS_W > OUT_W) ? POS_W : OUT_W;
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(TEXT_LEN_MAX);
  localparam int QD = 4;
  localparam int QP_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  logic             in_v_r;
  logic [7:0]       in_ch_r;
  logic             in_eot_r;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  tstart_r, tstart_nxt;
  logic [CNT_W-1:0]  tlen_r, tlen_nxt;
  logic [63:0]       prefix_r, prefix_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [7:0]        punct_r, punct_nxt;
  logic              star_r, star_nxt;

  res_t              q_r [QD];
  logic [QP_W-1:0]   wp_r, rp_r;
  logic [QC_W-1:0]   cnt_r;

  logic              proc;
  logic              pop;
  logic [7:0]        c;
  logic              eot;
  logic [CNT_W-1:0]  pos_inc, tstart_inc, tlen_inc;
  logic [VAL_W+3:0]  acc_wide;
  logic [VAL_W-1:0]  acc_sat;
  logic [KIND_W-1:0] wkind;
  logic              do_beg;
  logic              pre_v, beg_v;
  res_t              pre_res, beg_res;
  res_t              slot0, slot1;
  logic [1:0]        n_res;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < LEN_MAX) ? v + CNT_W'(1) : LEN_MAX;
  endfunction

  function automatic res_t mk(input logic [KIND_W-1:0] k, input logic [CNT_W-1:0] s,
                              input logic [CNT_W-1:0] l, input logic [VAL_W-1:0] v,
                              input logic [ERR_W-1:0] e);
    res_t r;
    r.kind       = k;
    r.start_res  = s[OUT_W-1:0];
    r.length     = l[OUT_W-1:0];
    r.value      = v;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

  assign proc      = in_v_r && (cnt_r <= QC_W'(QD - 2));
  assign in_tready = !in_v_r || proc;
  assign pop       = out_tvalid && out_tready;

  assign c          = in_ch_r;
  assign eot        = in_eot_r || (in_ch_r == 8'd0);
  assign pos_inc    = sat_inc(pos_r);
  assign tstart_inc = sat_inc(tstart_r);
  assign tlen_inc   = sat_inc(tlen_r);
  assign acc_wide   = ((VAL_W+4)'(acc_r) << 3) + ((VAL_W+4)'(acc_r) << 1) +
                      (VAL_W+4)'(c[3:0]);
  assign acc_sat    = (|acc_wide[VAL_W+3:VAL_W]) ? NUM_MAX : acc_wide[VAL_W-1:0];
  assign wkind      = (tlen_r > CNT_W'(8)) ? K_IDENT : kw_kind(prefix_r, tlen_r[3:0]);

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    prefix_nxt = prefix_r;
    acc_nxt    = acc_r;
    punct_nxt  = punct_r;
    star_nxt   = star_r;
    do_beg     = 1'b0;
    pre_v      = 1'b0;
    beg_v      = 1'b0;
    pre_res    = '0;
    beg_res    = '0;
    if (proc) begin
      if (eot) begin
        unique case (mode_r)
          M_PUNCT: begin
            pre_v = 1'b1;
            if (punct_r == "|") begin
              pre_res = mk(K_ERROR, tstart_r, '0, '0, E_INVALID);
            end else begin
              pre_res = mk(K_PUNCT, tstart_r, CNT_W'(1), '0, E_NONE);
            end
          end
          M_WORD: begin
            pre_v   = 1'b1;
            pre_res = mk(wkind, tstart_r, tlen_r, '0, E_NONE);
          end
          M_NUM: begin
            pre_v   = 1'b1;
            pre_res = mk(K_NUM, tstart_r, tlen_r, acc_r, E_NONE);
          end
          M_STR: begin
            pre_v   = 1'b1;
            pre_res = mk(K_ERROR, tstart_r, '0, '0, E_STR);
          end
          M_BCOM: begin
            pre_v   = 1'b1;
            pre_res = mk(K_ERROR, tstart_r, '0, '0, E_BCOM);
          end
          default: pre_v = 1'b0;
        endcase
        beg_v      = 1'b1;
        beg_res    = mk(K_EOF, pos_r, '0, '0, E_NONE);
        mode_nxt   = M_IDLE;
        pos_nxt    = '0;
        tstart_nxt = '0;
        tlen_nxt   = '0;
        prefix_nxt = '0;
        acc_nxt    = '0;
        punct_nxt  = '0;
        star_nxt   = 1'b0;
      end else begin
        pos_nxt = pos_inc;
        unique case (mode_r)
          M_PUNCT: begin
            if (punct_r == "/" && c == "/") begin
              mode_nxt = M_LCOM;
            end else if (punct_r == "/" && c == "*") begin
              mode_nxt = M_BCOM;
              star_nxt = 1'b0;
            end else if (is_pair(punct_r, c)) begin
              pre_v    = 1'b1;
              pre_res  = mk(K_PUNCT, tstart_r, CNT_W'(2), '0, E_NONE);
              mode_nxt = M_IDLE;
            end else if (punct_r == "|") begin
              pre_v    = 1'b1;
              pre_res  = mk(K_ERROR, tstart_r, '0, '0, E_INVALID);
              mode_nxt = M_ERR;
            end else begin
              pre_v   = 1'b1;
              pre_res = mk(K_PUNCT, tstart_r, CNT_W'(1), '0, E_NONE);
              do_beg  = 1'b1;
            end
          end
          M_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
              if (tlen_r < CNT_W'(8)) prefix_nxt = {prefix_r[55:0], c};
              tlen_nxt = tlen_inc;
            end else begin
              pre_v   = 1'b1;
              pre_res = mk(wkind, tstart_r, tlen_r, '0, E_NONE);
              do_beg  = 1'b1;
            end
          end
          M_NUM: begin
            if (is_digit(c)) begin
              acc_nxt  = acc_sat;
              tlen_nxt = tlen_inc;
            end else begin
              pre_v   = 1'b1;
              pre_res = mk(K_NUM, tstart_r, tlen_r, acc_r, E_NONE);
              do_beg  = 1'b1;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              pre_v    = 1'b1;
              pre_res  = mk(K_STR, tstart_inc, tlen_r, '0, E_NONE);
              mode_nxt = M_IDLE;
            end else begin
              tlen_nxt = tlen_inc;
            end
          end
          M_LCOM: begin
            if (c == "\n") mode_nxt = M_IDLE;
          end
          M_BCOM: begin
            if (star_r && c == "/") begin
              mode_nxt = M_IDLE;
              star_nxt = 1'b0;
            end else begin
              star_nxt = (c == "*");
            end
          end
          M_ERR: mode_nxt = M_ERR;
          default: do_beg = 1'b1;
        endcase
        if (do_beg) begin
          mode_nxt = M_IDLE;
          if (!is_space(c)) begin
            tstart_nxt = pos_r;
            tlen_nxt   = CNT_W'(1);
            priority if (c == "\"") begin
              mode_nxt = M_STR;
              tlen_nxt = '0;
            end else if (is_letter(c)) begin
              mode_nxt   = M_WORD;
              prefix_nxt = {56'd0, c};
            end else if (is_digit(c)) begin
              mode_nxt = M_NUM;
              acc_nxt  = VAL_W'(c[3:0]);
            end else if (is_pair_start(c)) begin
              mode_nxt  = M_PUNCT;
              punct_nxt = c;
            end else if (is_single_only(c)) begin
              beg_v   = 1'b1;
              beg_res = mk(K_PUNCT, pos_r, CNT_W'(1), '0, E_NONE);
            end else begin
              beg_v    = 1'b1;
              beg_res  = mk(K_ERROR, pos_r, '0, '0, E_INVALID);
              mode_nxt = M_ERR;
            end
          end
        end
      end
    end
  end

  always_comb begin
    slot0      = pre_v ? pre_res : beg_res;
    slot0.last = !(pre_v && beg_v);
    slot1      = beg_res;
    slot1.last = 1'b1;
    n_res      = {1'b0, pre_v} + {1'b0, beg_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      prefix_r <= '0;
      acc_r    <= '0;
      punct_r  <= '0;
      star_r   <= 1'b0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      prefix_r <= prefix_nxt;
      acc_r    <= acc_nxt;
      punct_r  <= punct_nxt;
      star_r   <= star_nxt;
      wp_r     <= wp_r + QP_W'(n_res);
      if (pop) rp_r <= rp_r + QP_W'(1);
      cnt_r    <= cnt_r + QC_W'(n_res) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r  <= in_tdata;
      in_eot_r <= in_tlast;
    end
    if (n_res != 2'd0) q_r[wp_r] <= slot0;
    if (n_res == 2'd2) q_r[wp_r + QP_W'(1)] <= slot1;
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {7'd0, q_r[rp_r].error_code, q_r[rp_r].value, q_r[rp_r].length,
                       q_r[rp_r].start_res};
  assign out_tuser  = q_r[rp_r].kind;
  assign out_tlast  = q_r[rp_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(QD))
    else $error("result queue overflow");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[104:103] != E_NONE) == (out_tuser == K_ERROR)))
    else $error("error code and kind disagree");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_ERR && !(proc && eot)) |=> (mode_r == M_ERR))
    else $error("left error mode before end of text");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LEN_MAX && tlen_r <= LEN_MAX)
    else $error("offset beyond saturation limit");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import csl_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } src_beat_t;

  typedef enum logic [2:0] {
    CH_SPACE, CH_LETTER, CH_DIGIT, CH_QUOTE, CH_LEAD, CH_SINGLE, CH_BAD
  } char_class_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;   // ch
  logic         in_tlast = 1'b0;   // end_of_text
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;         // start_res, length, value, error_code, zero pad
  logic [4:0]   out_tuser;         // kind
  logic         out_tlast;         // last

  c_subset_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  string pair_list = "==!=<=>=&&||++--+=-=*=/=%=->";
  string single_list = "+-*/()<>={}[];&,%!";
  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string kw_names [15] = '{"sizeof", "else", "return", "extern", "enum", "struct",
                           "typedef", "if", "while", "for", "int", "char", "void",
                           "break", "continue"};
  logic [4:0] kw_kinds [15] = '{K_PUNCT, K_PUNCT, K_RETURN, K_EXTERN, K_ENUM, K_STRUCT,
                                K_TYPEDEF, K_IF, K_WHILE, K_FOR, K_TYPE, K_TYPE, K_TYPE,
                                K_BREAK, K_CONTINUE};

  src_beat_t   src_q [$];
  res_t        token_q [$];
  res_t        step_toks [$];
  int unsigned beats_in = 0;
  int unsigned beats_total = 0;
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  assign send_idle_pct = (beats_in < 370) ? 36 : (beats_in < 740) ? 87 : 0;
  assign recv_idle_pct = (beats_in < 370) ? 87 : (beats_in < 740) ? 36 : 0;

  // lexer shadow state
  logic [2:0]  lx_mode = M_IDLE;
  logic [19:0] lx_pos = '0;
  logic [19:0] lx_start = '0;
  logic [19:0] lx_len = '0;
  logic [63:0] lx_word = '0;
  logic [62:0] lx_num = '0;
  logic [7:0]  lx_pend = '0;
  logic        lx_star = 1'b0;

  function automatic char_class_t classify(input logic [7:0] c);
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) return CH_SPACE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CH_LETTER;
    if (c >= "0" && c <= "9") return CH_DIGIT;
    case (c)
      8'h22: return CH_QUOTE;
      "=", "!", "<", ">", "&", "|", "+", "-", "*", "/", "%": return CH_LEAD;
      "(", ")", "{", "}", "[", "]", ";", ",": return CH_SINGLE;
      default: return CH_BAD;
    endcase
  endfunction

  function automatic logic is_two(input logic [7:0] p, input logic [7:0] c);
    int i;
    is_two = 1'b0;
    for (i = 0; i < 14; i++) begin
      if (pair_list[2*i] == p && pair_list[2*i+1] == c) is_two = 1'b1;
    end
  endfunction

  function automatic logic [19:0] sat20(input logic [19:0] v);
    return (v < TEXT_LEN_MAX_DEF) ? v + 20'd1 : v;
  endfunction

  function automatic logic [4:0] word_kind_of(input logic [63:0] w, input logic [19:0] n);
    int i;
    int k;
    string s;
    logic [63:0] pw;
    word_kind_of = K_IDENT;
    if (n <= 20'd8) begin
      for (i = 0; i < 15; i++) begin
        s = kw_names[i];
        if (s.len() == n) begin
          pw = '0;
          for (k = 0; k < s.len(); k++) pw = {pw[55:0], s[k]};
          if (pw == w) word_kind_of = kw_kinds[i];
        end
      end
    end
  endfunction

  task automatic tok_add(input logic [4:0] k, input logic [19:0] s, input logic [19:0] n,
                         input logic [62:0] v, input logic [1:0] e);
    res_t t;
    t.kind = k;
    t.start_res = s;
    t.length = n;
    t.value = v;
    t.error_code = e;
    t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic lex_open(input logic [7:0] c);
    char_class_t cc;
    cc = classify(c);
    lx_mode = M_IDLE;
    if (cc != CH_SPACE) begin
      lx_start = lx_pos;
      lx_len = 20'd1;
      case (cc)
        CH_QUOTE: begin
          lx_mode = M_STR;
          lx_len = 20'd0;
        end
        CH_LETTER: begin
          lx_mode = M_WORD;
          lx_word = {56'd0, c};
        end
        CH_DIGIT: begin
          lx_mode = M_NUM;
          lx_num = {55'd0, c - 8'h30};
        end
        CH_LEAD: begin
          lx_mode = M_PUNCT;
          lx_pend = c;
        end
        CH_SINGLE: tok_add(K_PUNCT, lx_pos, 20'd1, '0, E_NONE);
        default: begin
          tok_add(K_ERROR, lx_pos, 20'd0, '0, E_INVALID);
          lx_mode = M_ERR;
        end
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [62:0] d;
    char_class_t cc;
    cc = classify(c);
    case (lx_mode)
      M_PUNCT: begin
        if (lx_pend == "/" && c == "/") begin
          lx_mode = M_LCOM;
        end else if (lx_pend == "/" && c == "*") begin
          lx_mode = M_BCOM;
          lx_star = 1'b0;
        end else if (is_two(lx_pend, c)) begin
          tok_add(K_PUNCT, lx_start, 20'd2, '0, E_NONE);
          lx_mode = M_IDLE;
        end else if (lx_pend == "|") begin
          // lone bar
          tok_add(K_ERROR, lx_start, 20'd0, '0, E_INVALID);
          lx_mode = M_ERR;
        end else begin
          tok_add(K_PUNCT, lx_start, 20'd1, '0, E_NONE);
          lex_open(c);
        end
      end
      M_WORD: begin
        if (cc == CH_LETTER || cc == CH_DIGIT) begin
          if (lx_len < 20'd8) lx_word = {lx_word[55:0], c};
          lx_len = sat20(lx_len);
        end else begin
          tok_add(word_kind_of(lx_word, lx_len), lx_start, lx_len, '0, E_NONE);
          lex_open(c);
        end
      end
      M_NUM: begin
        if (cc == CH_DIGIT) begin
          d = {55'd0, c - 8'h30};
          if (lx_num > (NUM_MAX - d) / 63'd10) lx_num = NUM_MAX;
          else lx_num = lx_num * 63'd10 + d;
          lx_len = sat20(lx_len);
        end else begin
          tok_add(K_NUM, lx_start, lx_len, lx_num, E_NONE);
          lex_open(c);
        end
      end
      M_STR: begin
        if (c == 8'h22) begin
          tok_add(K_STR, sat20(lx_start), lx_len, '0, E_NONE);
          lx_mode = M_IDLE;
        end else begin
          lx_len = sat20(lx_len);
        end
      end
      M_LCOM: begin
        if (c == 8'h0a) lx_mode = M_IDLE;
      end
      M_BCOM: begin
        if (lx_star && c == "/") begin
          lx_mode = M_IDLE;
          lx_star = 1'b0;
        end else begin
          lx_star = (c == "*");
        end
      end
      M_ERR: ;
      default: lex_open(c);
    endcase
  endtask

  task automatic lex_step(input logic [7:0] c, input logic eot);
    res_t t;
    step_toks.delete();
    if (eot || c == 8'h00) begin
      case (lx_mode)
        M_PUNCT: begin
          if (lx_pend == "|") tok_add(K_ERROR, lx_start, 20'd0, '0, E_INVALID);
          else tok_add(K_PUNCT, lx_start, 20'd1, '0, E_NONE);
        end
        M_WORD: tok_add(word_kind_of(lx_word, lx_len), lx_start, lx_len, '0, E_NONE);
        M_NUM: tok_add(K_NUM, lx_start, lx_len, lx_num, E_NONE);
        M_STR: tok_add(K_ERROR, lx_start, 20'd0, '0, E_STR);
        M_BCOM: tok_add(K_ERROR, lx_start, 20'd0, '0, E_BCOM);
        default: ;
      endcase
      tok_add(K_EOF, lx_pos, 20'd0, '0, E_NONE);
      lx_mode = M_IDLE;
      lx_pos = '0;
      lx_start = '0;
      lx_len = '0;
      lx_word = '0;
      lx_num = '0;
      lx_pend = '0;
      lx_star = 1'b0;
    end else begin
      lex_byte(c);
      lx_pos = sat20(lx_pos);
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  // source text builders
  task automatic put_byte(input logic [7:0] c);
    src_beat_t b;
    b.ch = c;
    b.eot = 1'b0;
    src_q.push_back(b);
  endtask

  task automatic put_eot(input logic [7:0] c);
    src_beat_t b;
    b.ch = c;
    b.eot = 1'b1;
    src_q.push_back(b);
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_end();
    if ($urandom_range(0, 3) == 0) put_byte(8'h00);
    else put_eot(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] word_char(input logic first);
    return alnum[first ? $urandom_range(0, 52) : $urandom_range(0, 62)];
  endfunction

  function automatic logic [7:0] space_char();
    logic [7:0] c;
    c = 8'($urandom_range(8, 13));
    return (c == 8'd8) ? 8'h20 : c;
  endfunction

  task automatic gen_token();
    int r;
    int n;
    int i;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      put_text(kw_names[$urandom_range(0, 14)]);
      if ($urandom_range(0, 3) == 0) put_byte(word_char(1'b0));
    end else if (r < 34) begin
      n = $urandom_range(1, 11);
      for (i = 0; i < n; i++) put_byte(word_char(i == 0));
    end else if (r < 50) begin
      if ($urandom_range(0, 19) == 0) begin
        put_text("9223372036854775807");
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
        for (i = 0; i < n; i++) put_byte(8'($urandom_range(8'h30, 8'h39)));
      end
    end else if (r < 58) begin
      put_byte(8'h22);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        put_byte((c == 8'h22) ? 8'h41 : c);
      end
      put_byte(8'h22);
    end else if (r < 72) begin
      n = $urandom_range(0, 13);
      put_byte(pair_list[2*n]);
      put_byte(pair_list[2*n+1]);
    end else if (r < 86) begin
      put_byte(single_list[$urandom_range(0, 17)]);
    end else if (r < 90) begin
      put_text("//");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        put_byte((c == 8'h0a) ? 8'h20 : c);
      end
      put_byte(8'h0a);
    end else if (r < 95) begin
      put_text("/*");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) put_byte(($urandom_range(0, 2) == 0) ? "*" : word_char(1'b1));
      put_text("*/");
    end else begin
      // broken sequences
      case ($urandom_range(0, 2))
        0: begin
          put_text("/*");
          n = $urandom_range(0, 4);
          for (i = 0; i < n; i++) put_byte(word_char(1'b1));
          put_end();
        end
        1: begin
          put_byte(8'h22);
          n = $urandom_range(0, 4);
          for (i = 0; i < n; i++) put_byte(word_char(1'b0));
          put_end();
        end
        default: begin
          put_byte("|");
          put_byte(word_char(1'b1));
        end
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin : drv
    src_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'd0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_step(in_tdata, in_tlast);
        beats_in <= beats_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (src_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nb = src_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nb.ch;
          in_tlast <= nb.eot;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          $error("unexpected token beat: kind %0d start %0d", out_tuser, out_tdata[19:0]);
          err_cnt++;
        end else begin
          want = token_q.pop_front();
          if (want.kind !== out_tuser) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            err_cnt++;
          end
          if (want.start_res !== out_tdata[19:0]) begin
            $error("start_res: expected %0d, got %0d", want.start_res, out_tdata[19:0]);
            err_cnt++;
          end
          if (want.length !== out_tdata[39:20]) begin
            $error("length: expected %0d, got %0d", want.length, out_tdata[39:20]);
            err_cnt++;
          end
          if (want.value !== out_tdata[102:40]) begin
            $error("value: expected %0d, got %0d", want.value, out_tdata[102:40]);
            err_cnt++;
          end
          if (want.error_code !== out_tdata[104:103]) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_tdata[104:103]);
            err_cnt++;
          end
          if (want.last !== out_tlast) begin
            $error("last: expected %0d, got %0d", want.last, out_tlast);
            err_cnt++;
          end
        end
      end
      // long back-pressure stretch once, while the sender keeps offering
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= 800) begin
        out_tready <= 1'b0;
        hold_left <= 400;
        hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int pick;
    // directed texts
    put_text("x/*a");
    put_eot(8'hff);
    put_byte(8'h22);
    put_byte("s");
    put_byte(8'h00);
    put_text("|a;");
    put_eot(8'h5a);
    put_byte(8'hff);
    put_byte(8'h80);
    put_eot(8'h00);
    put_text("n+=12");
    put_eot(8'h01);
    put_text("/");
    put_eot(8'haa);
    put_eot(8'h55);
    // random texts
    while (src_q.size() < 1124) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        put_byte(8'($urandom_range(1, 255)));
      end else if (pick < 6) begin
        put_end();
      end else begin
        gen_token();
        if ($urandom_range(0, 99) < 55) put_byte(space_char());
      end
    end
    put_end();
    beats_total = src_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in != beats_total) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("c_subset_lexer verification clean");
    end else begin
      $display("c_subset_lexer verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("c_subset_lexer verification failed");
    $finish;
  end

endmodule
